// File: rtl/pbd_pkg.sv
// Shared types, codes and helper functions for the protobuf data message decoder.
`default_nettype none

package pbd_pkg;

  // The payload fits when its length is below this capacity minus one.
  localparam int unsigned PAYLOAD_CAPACITY = 256;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned FIELD_W = 5;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned VALUE_W = 28;
  localparam int unsigned PHASE_W = 3;

  // Parser phases
  localparam logic [PHASE_W-1:0] PH_TAG    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_VARINT = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEN    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BODY   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_IGNORE = 3'd4;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_VARINT = 3'd0;
  localparam logic [KIND_W-1:0] EV_HEADER = 3'd1;
  localparam logic [KIND_W-1:0] EV_BYTE   = 3'd2;
  localparam logic [KIND_W-1:0] EV_DONE   = 3'd3;
  localparam logic [KIND_W-1:0] EV_ERROR  = 3'd4;

  // Wire types
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_LEN    = 3'd2;

  // Field numbers with a meaning
  localparam logic [FIELD_W-1:0] FLD_PORT     = 5'd1;
  localparam logic [FIELD_W-1:0] FLD_PAYLOAD  = 5'd2;
  localparam logic [FIELD_W-1:0] FLD_WANT     = 5'd3;
  localparam logic [FIELD_W-1:0] FLD_DEST     = 5'd4;
  localparam logic [FIELD_W-1:0] FLD_SOURCE   = 5'd5;
  localparam logic [FIELD_W-1:0] FLD_REQUEST  = 5'd6;
  localparam logic [FIELD_W-1:0] FLD_REPLY    = 5'd7;
  localparam logic [FIELD_W-1:0] FLD_EMOJI    = 5'd8;
  localparam logic [FIELD_W-1:0] FLD_WANT_ALT = 5'd9;
  localparam logic [FIELD_W-1:0] FLD_BITFIELD = 5'd10;

  // Target slots
  localparam logic [SLOT_W-1:0] SLOT_PORT     = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_WANT     = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_DEST     = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_SOURCE   = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_REQUEST  = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_REPLY    = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_EMOJI    = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_BITFIELD = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_UNKNOWN  = 4'd8;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] field;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic               stored;
    logic [BYTE_W-1:0]  data;
    logic               last;
  } pbd_res_t;

  // Results of one byte handed from the parser to the result buffer
  typedef struct packed {
    logic     valid;
    logic     two;
    pbd_res_t first;
    pbd_res_t second;
  } pbd_push_t;

  function automatic pbd_res_t map_varint(input logic [FIELD_W-1:0] fld,
                                          input logic [VALUE_W-1:0] v);
    pbd_res_t r;
    r        = '0;
    r.kind   = EV_VARINT;
    r.field  = fld;
    r.value  = v;
    case (fld)
      FLD_PORT: begin
        r.slot  = SLOT_PORT;
        r.value = {20'd0, v[7:0]};
      end
      FLD_WANT, FLD_WANT_ALT: begin
        r.slot  = SLOT_WANT;
        r.value = {27'd0, (v != '0)};
      end
      FLD_DEST:     r.slot = SLOT_DEST;
      FLD_SOURCE:   r.slot = SLOT_SOURCE;
      FLD_REQUEST:  r.slot = SLOT_REQUEST;
      FLD_REPLY:    r.slot = SLOT_REPLY;
      FLD_EMOJI:    r.slot = SLOT_EMOJI;
      FLD_BITFIELD: r.slot = SLOT_BITFIELD;
      default:      r.slot = SLOT_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pbd_in_if.sv
// Input byte channel: valid/ready with one message byte and its last mark.
`default_nettype none

interface pbd_in_if;
  logic                         valid;
  logic                         ready;
  logic [pbd_pkg::BYTE_W-1:0]   data_byte;
  logic                         last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/pbd_out_if.sv
// Result channel: valid/ready with one decoded event per beat.
`default_nettype none

interface pbd_out_if;
  logic                          valid;
  logic                          ready;
  logic [pbd_pkg::KIND_W-1:0]    event_kind;
  logic [pbd_pkg::FIELD_W-1:0]   field_number;
  logic [pbd_pkg::SLOT_W-1:0]    target_slot;
  logic [pbd_pkg::VALUE_W-1:0]   field_value;
  logic                          payload_stored;
  logic [pbd_pkg::BYTE_W-1:0]    payload_data;
  logic                          last_result;

  modport source (output valid, output event_kind, output field_number, output target_slot,
                  output field_value, output payload_stored, output payload_data,
                  output last_result, input ready);
  modport sink   (input valid, input event_kind, input field_number, input target_slot,
                  input field_value, input payload_stored, input payload_data,
                  input last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/pbd_parser.sv
// Byte input register, parse state and per-byte event decode.
`default_nettype none

module pbd_parser #(
  parameter int unsigned VARINT_MAX_BYTES = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pbd_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic                        in_last_byte,
  input  wire logic                        buf_free,
  output pbd_pkg::pbd_push_t               push
);

  localparam int unsigned CNT_W = (VARINT_MAX_BYTES > 1) ? $clog2(VARINT_MAX_BYTES) : 1;

  // Input register
  logic                       inq_valid_r, inq_valid_nxt;
  logic [pbd_pkg::BYTE_W-1:0] inq_byte_r;
  logic                       inq_last_r;
  logic                       advance;

  // Parse state
  logic [pbd_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [pbd_pkg::FIELD_W-1:0] field_r, field_nxt;
  logic [pbd_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [pbd_pkg::BYTE_W-1:0]  rem_r, rem_nxt;
  logic                        bip_r, bip_nxt;

  logic [CNT_W:0]              cnt_inc;
  logic [5:0]                  sh_amt;
  logic [34:0]                 grp_shifted;
  logic [pbd_pkg::VALUE_W-1:0] acc_new;
  logic                        stored;
  logic                        pv, dv, bad;
  pbd_pkg::pbd_res_t           prim, done_res;

  assign advance       = inq_valid_r && buf_free;
  assign in_ready      = !inq_valid_r || advance;
  assign inq_valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : inq_valid_r);

  assign cnt_inc     = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};
  assign sh_amt      = 6'(cnt_r) * 6'd7;
  assign grp_shifted = {28'd0, inq_byte_r[6:0]} << sh_amt;
  assign acc_new     = acc_r | grp_shifted[pbd_pkg::VALUE_W-1:0];
  assign stored      = {1'b0, inq_byte_r} < 9'(pbd_pkg::PAYLOAD_CAPACITY - 1);

  always_comb begin
    phase_nxt = phase_r;
    field_nxt = field_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    bip_nxt   = bip_r;
    prim      = '0;
    done_res  = '0;
    done_res.kind = pbd_pkg::EV_DONE;
    pv        = 1'b0;
    dv        = 1'b0;
    bad       = 1'b0;
    if (advance) begin
      case (phase_r)
        pbd_pkg::PH_TAG: begin
          if ((inq_byte_r[2:0] != pbd_pkg::WT_VARINT && inq_byte_r[2:0] != pbd_pkg::WT_LEN)
              || inq_last_r) begin
            pv         = 1'b1;
            bad        = 1'b1;
            prim.kind  = pbd_pkg::EV_ERROR;
            prim.field = inq_byte_r[7:3];
            phase_nxt  = pbd_pkg::PH_IGNORE;
          end else begin
            field_nxt = inq_byte_r[7:3];
            acc_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = (inq_byte_r[2:0] == pbd_pkg::WT_VARINT) ? pbd_pkg::PH_VARINT
                                                                 : pbd_pkg::PH_LEN;
          end
        end
        pbd_pkg::PH_VARINT: begin
          acc_nxt = acc_new;
          cnt_nxt = cnt_inc[CNT_W-1:0];
          if (!inq_byte_r[7] || cnt_inc >= (CNT_W+1)'(VARINT_MAX_BYTES) || inq_last_r) begin
            pv        = 1'b1;
            prim      = pbd_pkg::map_varint(field_r, acc_new);
            phase_nxt = pbd_pkg::PH_TAG;
          end
        end
        pbd_pkg::PH_LEN: begin
          bip_nxt = 1'b0;
          if (field_r == pbd_pkg::FLD_PAYLOAD) begin
            pv          = 1'b1;
            prim.kind   = pbd_pkg::EV_HEADER;
            prim.field  = pbd_pkg::FLD_PAYLOAD;
            prim.value  = {20'd0, inq_byte_r};
            prim.stored = stored;
            bip_nxt     = stored;
          end
          rem_nxt   = inq_byte_r;
          phase_nxt = (inq_byte_r == '0) ? pbd_pkg::PH_TAG : pbd_pkg::PH_BODY;
        end
        pbd_pkg::PH_BODY: begin
          if (bip_r) begin
            pv          = 1'b1;
            prim.kind   = pbd_pkg::EV_BYTE;
            prim.field  = field_r;
            prim.stored = 1'b1;
            prim.data   = inq_byte_r;
          end
          rem_nxt = rem_r - 8'd1;
          if (rem_nxt == '0) phase_nxt = pbd_pkg::PH_TAG;
        end
        default: ; // ignore phase: drop the byte
      endcase
      if (inq_last_r) begin
        dv        = !bad && (phase_r != pbd_pkg::PH_IGNORE);
        phase_nxt = pbd_pkg::PH_TAG;
        field_nxt = '0;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        rem_nxt   = '0;
        bip_nxt   = 1'b0;
      end
    end
  end

  // Order results: the byte's own event first, done after it.
  always_comb begin
    push.valid       = advance && (pv || dv);
    push.two         = pv && dv;
    push.first       = pv ? prim : done_res;
    push.first.last  = !(pv && dv);
    push.second      = done_res;
    push.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      phase_r     <= pbd_pkg::PH_TAG;
      field_r     <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      rem_r       <= '0;
      bip_r       <= 1'b0;
    end else begin
      inq_valid_r <= inq_valid_nxt;
      phase_r     <= phase_nxt;
      field_r     <= field_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      bip_r       <= bip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte_r <= in_data_byte;
      inq_last_r <= in_last_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pbd_out_buf.sv
// Two-entry result buffer that drains one event per beat.
`default_nettype none

module pbd_out_buf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pbd_pkg::pbd_push_t push,
  output logic                    buf_free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pbd_pkg::pbd_res_t       head
);

  logic [1:0]        cnt_r, cnt_nxt;
  pbd_pkg::pbd_res_t e0_r, e0_nxt;
  pbd_pkg::pbd_res_t e1_r, e1_nxt;
  logic              pop;

  assign out_valid = (cnt_r != 2'd0);
  assign head      = e0_r;
  assign pop       = out_valid && out_ready;
  // Empty after this edge: a new byte's results may land.
  assign buf_free  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    if (push.valid) begin
      e0_nxt  = push.first;
      e1_nxt  = push.second;
      cnt_nxt = push.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      e0_nxt  = e1_r;
      cnt_nxt = cnt_r - 2'd1;
    end else if (buf_free && cnt_r == 2'd1) begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/protobuf_data_message_decoder.sv
// Top level of the streaming protobuf data message decoder.
//
//   channel  | dir | beat                                   | handshake
//   ---------+-----+----------------------------------------+-------------------------
//   in_bus   | in  | data_byte[7:0], last_byte              | valid & ready
//   out_bus  | out | event_kind, field_number, target_slot, | valid & ready
//            |     | field_value, payload_stored,           |
//            |     | payload_data, last_result              |
//
// One byte per cycle while out_bus is ready and no byte causes two results: a byte
// is registered in the input register, is decoded in a single pass against the parse
// state, and its results land in a two-entry result buffer. A byte that causes two
// results (its own event plus done) holds the next byte while the buffer drains.
// Synchronous active-low reset returns the parser to tag phase and empties both
// registers. A stalled out_bus holds the buffer, which backs up into the input
// register and then drops in_bus.ready.
`default_nettype none

module protobuf_data_message_decoder #(
  parameter int unsigned VARINT_MAX_BYTES = 4
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  pbd_in_if.sink       in_bus,
  pbd_out_if.source    out_bus
);

  pbd_pkg::pbd_push_t push;
  pbd_pkg::pbd_res_t  head;
  logic               buf_free;
  logic               out_valid;

  // Decode: input register plus parse state
  pbd_parser #(
    .VARINT_MAX_BYTES (VARINT_MAX_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bus.valid),
    .in_ready     (in_bus.ready),
    .in_data_byte (in_bus.data_byte),
    .in_last_byte (in_bus.last_byte),
    .buf_free     (buf_free),
    .push         (push)
  );

  // Result register: hold up to two events per byte
  pbd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .buf_free  (buf_free),
    .out_valid (out_valid),
    .out_ready (out_bus.ready),
    .head      (head)
  );

  // Drive the result beat from the buffer head
  assign out_bus.valid          = out_valid;
  assign out_bus.event_kind     = head.kind;
  assign out_bus.field_number   = head.field;
  assign out_bus.target_slot    = head.slot;
  assign out_bus.field_value    = head.value;
  assign out_bus.payload_stored = head.stored;
  assign out_bus.payload_data   = head.data;
  assign out_bus.last_result    = head.last;

endmodule

`default_nettype wire
